// File: hdl/sqd_pkg.sv
// types and constants shared by the shortest queue dispatcher
`default_nettype none

package sqd_pkg;

   localparam int CFG_W = 3;
   localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd4;

   typedef struct packed {
      logic       job_arrives;
      logic [7:0] service_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  chosen_queue;
      logic        job_stored;
      logic [31:0] job_finish;
      logic [3:0]  completed_mask;
      logic [47:0] stay_total;
      logic [31:0] job_total;
      logic [31:0] tick_now;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/sqd_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module sqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/shortest_queue_dispatcher_top.sv
// shortest queue dispatcher: one request per tick, join shortest queue, timed departures
// the request is registered in S_IDLE, the response in S_CALC once the last one was taken
// a new request is taken only in S_IDLE; S_FILL first refills each queue that pops and stays
//   non-empty, one head at a time through the single read port of the finish time ram
// reset: synchronous, clears pointers, occupancy, counters and totals at once
// the finish time ram is not cleared; an entry is only read after it was written
`default_nettype none

module shortest_queue_dispatcher_top
   import sqd_pkg::*;
#(
   parameter int QUEUE_COUNT = 4,
   parameter int QUEUE_DEPTH = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_data
);

   localparam int Q_W    = $clog2(QUEUE_COUNT);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(QUEUE_COUNT * QUEUE_DEPTH);
   localparam int LEAVES = 1 << Q_W;
   localparam int NODES  = 2 * LEAVES - 1;

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_FILL} state_type;

   function automatic logic [ADDR_W-1:0] entry_addr(input logic [Q_W-1:0] q,
                                                   input logic [PTR_W-1:0] p);
      return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] aq_ff, aq_in;
   logic [OCC_W-1:0] occ_ff [QUEUE_COUNT];
   logic [OCC_W-1:0] occ_in [QUEUE_COUNT];
   logic [PTR_W-1:0] head_ptr_ff [QUEUE_COUNT];
   logic [PTR_W-1:0] head_ptr_in [QUEUE_COUNT];
   logic [PTR_W-1:0] tail_ptr_ff [QUEUE_COUNT];
   logic [PTR_W-1:0] tail_ptr_in [QUEUE_COUNT];
   logic [31:0]      head_val_ff [QUEUE_COUNT];
   logic [31:0]      head_val_in [QUEUE_COUNT];
   logic [31:0]      tail_val_ff [QUEUE_COUNT];
   logic [31:0]      tail_val_in [QUEUE_COUNT];
   logic [31:0]      tick_ff, tick_in;
   logic [47:0]      stay_ff, stay_in;
   logic [31:0]      count_ff, count_in;
   logic [QUEUE_COUNT-1:0] pend_ff, pend_in;
   logic             rd_out_ff, rd_out_in;
   logic [Q_W-1:0]   rd_q_ff, rd_q_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             job_ff, job_in;
   logic [Q_W-1:0]   pick_ff, pick_in;
   logic [31:0]      finish_ff, finish_in;
   logic             empty_ff, empty_in;
   logic             room_ff, room_in;

   logic [QUEUE_COUNT-1:0] active;
   logic [OCC_W:0]   node_occ [NODES];
   logic [Q_W-1:0]   node_idx [NODES];
   logic [Q_W-1:0]   pick;
   logic [31:0]      base;
   logic [32:0]      finish_sum;

   logic             stored;
   logic [OCC_W-1:0] occ_post [QUEUE_COUNT];
   logic [31:0]      head_post [QUEUE_COUNT];
   logic [QUEUE_COUNT-1:0] pop_mask;
   logic [QUEUE_COUNT-1:0] refill_mask;
   logic [31:0]      stay_diff;
   logic [48:0]      stay_sum;
   logic [31:0]      mask_wide;
   logic [31:0]      pick_wide;
   logic [Q_W-1:0]   fill_sel;

   logic             ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic             ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [31:0]      ram_rd_data;

   sqd_ram #(
      .WIDTH(32),
      .DEPTH(QUEUE_COUNT * QUEUE_DEPTH)
   ) u_finish_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(finish_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // queue 0 always takes part; register values above the queue count act as the queue count
   always_comb begin
      for (int j = 0; j < QUEUE_COUNT; j++) begin
         active[j] = (j == 0) || (32'(aq_ff) > j);
      end
   end

   // registered-free tournament tree, ties keep the lower index
   always_comb begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
         node_occ[LEAVES-1+i] = active[i] ? {1'b0, occ_ff[i]} : '1;
         node_idx[LEAVES-1+i] = Q_W'(i);
      end
      for (int i = QUEUE_COUNT; i < LEAVES; i++) begin
         node_occ[LEAVES-1+i] = '1;
         node_idx[LEAVES-1+i] = Q_W'(i);
      end
      for (int i = LEAVES - 2; i >= 0; i--) begin
         if (node_occ[2*i+2] < node_occ[2*i+1]) begin
            node_occ[i] = node_occ[2*i+2];
            node_idx[i] = node_idx[2*i+2];
         end else begin
            node_occ[i] = node_occ[2*i+1];
            node_idx[i] = node_idx[2*i+1];
         end
      end
   end

   assign pick       = node_idx[0];
   assign base       = (occ_ff[pick] == '0) ? tick_ff : tail_val_ff[pick];
   assign finish_sum = {1'b0, base} + {25'd0, req_data.service_ticks};

   // per queue view after the push, then departures
   assign stored = job_ff && room_ff;

   always_comb begin
      for (int j = 0; j < QUEUE_COUNT; j++) begin
         occ_post[j]  = occ_ff[j];
         head_post[j] = head_val_ff[j];
         if (stored && (pick_ff == Q_W'(j))) begin
            occ_post[j] = occ_ff[j] + 1'b1;
            if (empty_ff) begin
               head_post[j] = finish_ff;
            end
         end
         pop_mask[j]    = active[j] && (occ_post[j] != '0) && (tick_ff >= head_post[j]);
         refill_mask[j] = pop_mask[j] && (occ_post[j] != OCC_W'(1));
      end
   end

   assign stay_diff = finish_ff - tick_ff;
   assign stay_sum  = {1'b0, stay_ff} + {17'd0, stay_diff};
   assign mask_wide = 32'(pop_mask);
   assign pick_wide = 32'(pick_ff);

   always_comb begin
      fill_sel = '0;
      for (int j = QUEUE_COUNT - 1; j >= 0; j--) begin
         if (pend_ff[j]) begin
            fill_sel = Q_W'(j);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      aq_in        = aq_ff;
      occ_in       = occ_ff;
      head_ptr_in  = head_ptr_ff;
      tail_ptr_in  = tail_ptr_ff;
      head_val_in  = head_val_ff;
      tail_val_in  = tail_val_ff;
      tick_in      = tick_ff;
      stay_in      = stay_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      rd_out_in    = 1'b0;
      rd_q_in      = rd_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      job_in       = job_ff;
      pick_in      = pick_ff;
      finish_in    = finish_ff;
      empty_in     = empty_ff;
      room_in      = room_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = entry_addr(pick_ff, tail_ptr_ff[pick_ff]);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = entry_addr(fill_sel, head_ptr_ff[fill_sel]);

      if (csr_valid) begin
         aq_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               job_in   = req_data.job_arrives;
               state_in = S_CALC;
               if (req_data.job_arrives) begin
                  pick_in   = pick;
                  empty_in  = (occ_ff[pick] == '0);
                  room_in   = (occ_ff[pick] < OCC_W'(QUEUE_DEPTH));
                  finish_in = finish_sum[32] ? 32'hFFFF_FFFF : finish_sum[31:0];
               end else begin
                  pick_in   = '0;
                  empty_in  = 1'b0;
                  room_in   = 1'b0;
                  finish_in = '0;
               end
            end
         end
         S_CALC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ram_wr_en = stored;
               if (job_ff) begin
                  if (finish_ff >= tick_ff) begin
                     stay_in = stay_sum[48] ? 48'hFFFF_FFFF_FFFF : stay_sum[47:0];
                  end
                  if (count_ff != 32'hFFFF_FFFF) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               for (int j = 0; j < QUEUE_COUNT; j++) begin
                  occ_in[j] = occ_post[j] - OCC_W'(pop_mask[j]);
                  if (pop_mask[j]) begin
                     head_ptr_in[j] = next_ptr(head_ptr_ff[j]);
                  end
                  if (stored && (pick_ff == Q_W'(j))) begin
                     tail_ptr_in[j] = next_ptr(tail_ptr_ff[j]);
                     tail_val_in[j] = finish_ff;
                     if (empty_ff) begin
                        head_val_in[j] = finish_ff;
                     end
                  end
               end
               tick_in      = tick_ff + 1'b1;
               pend_in      = refill_mask;
               rsp_valid_in = 1'b1;
               rsp_data_in.chosen_queue   = pick_wide[1:0];
               rsp_data_in.job_stored     = stored;
               rsp_data_in.job_finish     = finish_ff;
               rsp_data_in.completed_mask = mask_wide[3:0];
               rsp_data_in.stay_total     = (job_ff && (finish_ff >= tick_ff)) ?
                                            (stay_sum[48] ? 48'hFFFF_FFFF_FFFF : stay_sum[47:0]) :
                                            stay_ff;
               rsp_data_in.job_total      = (job_ff && (count_ff != 32'hFFFF_FFFF)) ?
                                            count_ff + 1'b1 : count_ff;
               rsp_data_in.tick_now       = tick_ff;
               state_in = (refill_mask != '0) ? S_FILL : S_IDLE;
            end
         end
         S_FILL: begin
            // the ram read data, flagged by rd_out_ff, is written to the head value of queue rd_q_ff
            if (rd_out_ff) begin
               head_val_in[rd_q_ff] = ram_rd_data;
            end
            if (pend_ff != '0) begin
               ram_rd_en          = 1'b1;
               rd_out_in          = 1'b1;
               rd_q_in            = fill_sel;
               pend_in[fill_sel]  = 1'b0;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         aq_ff        <= ACTIVE_RESET;
         for (int j = 0; j < QUEUE_COUNT; j++) begin
            occ_ff[j]      <= '0;
            head_ptr_ff[j] <= '0;
            tail_ptr_ff[j] <= '0;
         end
         tick_ff      <= '0;
         stay_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= '0;
         rd_out_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         aq_ff        <= aq_in;
         occ_ff       <= occ_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         tick_ff      <= tick_in;
         stay_ff      <= stay_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rd_out_ff    <= rd_out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      rd_q_ff     <= rd_q_in;
      rsp_data_ff <= rsp_data_in;
      job_ff      <= job_in;
      pick_ff     <= pick_in;
      finish_ff   <= finish_in;
      empty_ff    <= empty_in;
      room_ff     <= room_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/sqd_checker.sv
// port level checks for the shortest queue dispatcher, bound to its top level
`default_nettype none

module sqd_checker
   import sqd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   logic        seen_ff, seen_in;
   logic [31:0] last_tick_ff, last_tick_in;
   logic [31:0] last_jobs_ff, last_jobs_in;
   logic        rsp_acc;

   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      seen_in      = seen_ff || rsp_acc;
      last_tick_in = rsp_acc ? rsp_data.tick_now : last_tick_ff;
      last_jobs_in = rsp_acc ? rsp_data.job_total : last_jobs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_tick_ff <= '0;
         last_jobs_ff <= '0;
      end else begin
         seen_ff      <= seen_in;
         last_tick_ff <= last_tick_in;
         last_jobs_ff <= last_jobs_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_first_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !seen_ff |-> rsp_data.tick_now == 32'd0)
      else $error("first response after reset not at tick zero");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && seen_ff |-> rsp_data.tick_now == last_tick_ff + 32'd1)
      else $error("tick skipped or repeated");

   a_jobs_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && seen_ff |->
         rsp_data.job_total == last_jobs_ff || rsp_data.job_total == last_jobs_ff + 32'd1)
      else $error("job total moved by more than one");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && seen_ff && rsp_data.job_total == last_jobs_ff &&
      last_jobs_ff != 32'hFFFF_FFFF |-> !rsp_data.job_stored && rsp_data.job_finish == 32'd0)
      else $error("tick without a job reports a stored job");

endmodule

bind shortest_queue_dispatcher_top sqd_checker u_sqd_checker (.*);

`default_nettype wire
